[design/gid_pkg.sv]
// ---------------------------------------------------------------------------
// GPIO interrupt debouncer package
// Shared widths, register indexes, codes and the result struct.
// ---------------------------------------------------------------------------
package gid_pkg;

	// Configuration port widths.
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 16;

	// Register widths.
	localparam int DEB_BITS  = 16;
	localparam int TRIG_BITS = 3;

	// Register indexes on the configuration port.
	localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE_TICKS = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FILTER_MODE    = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TRIGGER_TYPE   = 2'd2;

	// Request action codes.
	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_EDGE = 1'b1;

	// Debounce modes.
	localparam logic MODE_COOLDOWN = 1'b0;
	localparam logic MODE_DELAY    = 1'b1;

	// Trigger types; the remaining codes act like both edges.
	localparam logic [TRIG_BITS-1:0] TRIG_RISING  = 3'd0;
	localparam logic [TRIG_BITS-1:0] TRIG_FALLING = 3'd1;
	localparam logic [TRIG_BITS-1:0] TRIG_BOTH    = 3'd2;
	localparam logic [TRIG_BITS-1:0] TRIG_HIGH    = 3'd3;
	localparam logic [TRIG_BITS-1:0] TRIG_LOW     = 3'd4;

	// Result handed from the core to the output register.
	typedef struct packed {
		logic valid;
		logic level;
	} result_t;

endpackage

[design/gid_if.sv]
// ---------------------------------------------------------------------------
// GPIO interrupt debouncer channels
// Valid/ready channels for requests and for reports.
// ---------------------------------------------------------------------------
interface gid_in_if;
	logic valid;
	logic ready;
	logic action;
	logic pin_level;

	modport source (output valid, output action, output pin_level, input ready);
	modport sink (input valid, input action, input pin_level, output ready);
endinterface

interface gid_out_if;
	logic valid;
	logic ready;
	logic reported_level;

	modport source (output valid, output reported_level, input ready);
	modport sink (input valid, input reported_level, output ready);
endinterface

[design/gid_core.sv]
// ---------------------------------------------------------------------------
// GPIO interrupt debouncer core
// Request register, debounce state and the per-request decision logic.
// ---------------------------------------------------------------------------
module gid_core #(
	parameter int TICK_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	gid_in_if.sink                              items,
	input  logic                                cfg_we,
	input  logic [gid_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [gid_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic                                out_free,
	output gid_pkg::result_t                    res
);

	localparam int CMP_BITS = (TICK_BITS > gid_pkg::DEB_BITS) ? TICK_BITS : gid_pkg::DEB_BITS;

	// Request register.
	logic v_s1;
	logic action_s1;
	logic level_s1;

	// Configuration registers.
	logic [gid_pkg::DEB_BITS-1:0]  deb_q;
	logic                          mode_q;
	logic [gid_pkg::TRIG_BITS-1:0] trig_q;

	// Debounce state.
	logic [TICK_BITS-1:0]         tick_q, tick_d;
	logic [TICK_BITS-1:0]         last_q, last_d;
	logic                         latched_q, latched_d;
	logic [gid_pkg::DEB_BITS-1:0] cnt_q, cnt_d;
	logic                         run_q, run_d;

	logic                         advance;
	logic                         accept;
	logic [gid_pkg::DEB_BITS-1:0] cnt_dec;
	logic [TICK_BITS-1:0]         gap;
	logic                         gap_ok;
	logic                         suits;

	// The request register moves on whenever the output register can take a result.
	assign advance     = v_s1 & out_free;
	assign items.ready = ~v_s1 | advance;
	assign accept      = items.valid & items.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= items.action;
			level_s1  <= items.pin_level;
		end
	end

	// Countdown step, stopping at zero.
	assign cnt_dec = (cnt_q != '0) ? cnt_q - 1'b1 : '0;

	// Absolute distance between the current tick and the last report.
	assign gap    = (tick_q > last_q) ? tick_q - last_q : last_q - tick_q;
	assign gap_ok = CMP_BITS'(gap) >= CMP_BITS'(deb_q);

	// Does the latched level fit the trigger type?
	always_comb begin
		unique case (trig_q)
			gid_pkg::TRIG_RISING, gid_pkg::TRIG_HIGH:  suits = latched_q;
			gid_pkg::TRIG_FALLING, gid_pkg::TRIG_LOW:  suits = ~latched_q;
			default:                                   suits = 1'b1;
		endcase
	end

	// Next state and result for the request in the register.
	always_comb begin
		tick_d    = tick_q;
		last_d    = last_q;
		latched_d = latched_q;
		cnt_d     = cnt_q;
		run_d     = run_q;
		res.valid = 1'b0;
		res.level = level_s1;
		if (cfg_we) begin
			// Timing writes clear the report stamp and may drop a pending delay.
			if (cfg_index == gid_pkg::REG_DEBOUNCE_TICKS) begin
				last_d = '0;
				if (mode_q == gid_pkg::MODE_COOLDOWN || cfg_data[gid_pkg::DEB_BITS-1:0] == '0) begin
					run_d = 1'b0;
					cnt_d = '0;
				end
			end else if (cfg_index == gid_pkg::REG_FILTER_MODE) begin
				last_d = '0;
				if (cfg_data[0] == gid_pkg::MODE_COOLDOWN || deb_q == '0) begin
					run_d = 1'b0;
					cnt_d = '0;
				end
			end
		end else if (advance) begin
			if (action_s1 == gid_pkg::ACT_TICK) begin
				tick_d = tick_q + 1'b1;
				if (run_q) begin
					cnt_d = cnt_dec;
					if (cnt_dec == '0) begin
						run_d = 1'b0;
						if (latched_q == level_s1 && suits) begin
							res.valid = 1'b1;
						end
					end
				end
			end else if (deb_q == '0) begin
				res.valid = 1'b1;
			end else if (mode_q == gid_pkg::MODE_COOLDOWN) begin
				if (gap_ok) begin
					last_d    = tick_q;
					res.valid = 1'b1;
				end
			end else begin
				latched_d = level_s1;
				cnt_d     = deb_q;
				run_d     = 1'b1;
			end
		end
	end

	// Configuration and state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_q     <= '0;
			mode_q    <= gid_pkg::MODE_COOLDOWN;
			trig_q    <= gid_pkg::TRIG_BOTH;
			tick_q    <= '0;
			last_q    <= '0;
			latched_q <= 1'b0;
			cnt_q     <= '0;
			run_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					gid_pkg::REG_DEBOUNCE_TICKS: deb_q  <= cfg_data[gid_pkg::DEB_BITS-1:0];
					gid_pkg::REG_FILTER_MODE:    mode_q <= cfg_data[0];
					gid_pkg::REG_TRIGGER_TYPE:   trig_q <= cfg_data[gid_pkg::TRIG_BITS-1:0];
					default: ;
				endcase
			end
			tick_q    <= tick_d;
			last_q    <= last_d;
			latched_q <= latched_d;
			cnt_q     <= cnt_d;
			run_q     <= run_d;
		end
	end

endmodule

[design/gid_out_stage.sv]
// ---------------------------------------------------------------------------
// GPIO interrupt debouncer output stage
// Result register that holds a report until the receiver takes it.
// ---------------------------------------------------------------------------
module gid_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  gid_pkg::result_t res,
	output logic             out_free,
	gid_out_if.source        results
);

	logic valid_q;
	logic level_q;

	// The register can load when empty or when its report leaves this cycle.
	assign out_free = ~valid_q | results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res.valid) begin
			level_q <= res.level;
		end
	end

	assign results.valid          = valid_q;
	assign results.reported_level = level_q;

endmodule

[design/gpio_interrupt_debouncer.sv]
// ---------------------------------------------------------------------------
// GPIO interrupt debouncer
// Debounces the edge interrupts of one input pin against a tick time base.
// ---------------------------------------------------------------------------
// Requests arrive on the items channel: a tick (time moves on by one) or an
// edge interrupt carrying the sampled pin level. Qualified reports leave on
// the results channel with the reported level. A request yields zero or one
// report. Registers are written through cfg_we, cfg_index and cfg_data; the
// user must write them only while the block is idle, as the block itself does
// not enforce it. An index beyond the register list is ignored.
// A request is taken into a request register, evaluated there against the
// debounce state, and its report is loaded into the result register when
// that register is free. One request is taken every cycle as long as the
// result register drains.
// Reset clears the tick counter, the report stamp and any pending delay, and
// sets the trigger type to both edges. When the receiver stalls, a waiting
// report holds and one more request is still accepted into the request
// register before the items channel stalls too.
module gpio_interrupt_debouncer #(
	parameter int TICK_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	gid_in_if.sink                              items,
	gid_out_if.source                           results,
	input  logic                                cfg_we,
	input  logic [gid_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [gid_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	gid_pkg::result_t res;
	logic             out_free;

	// Decision logic and debounce state.
	gid_core #(
		.TICK_BITS (TICK_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_free  (out_free),
		.res       (res)
	);

	// Result register toward the receiver.
	gid_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.out_free (out_free),
		.results  (results)
	);

endmodule

[sim/gid_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// GPIO interrupt debouncer checker
// Watches the request, report and register ports, keeps its own copy of the
// debounce state, and compares every report with the oldest expected level.
// ---------------------------------------------------------------------------
module gid_checker #(
	parameter int TICK_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	gid_in_if                                  items,
	gid_out_if                                 results,
	input  logic                               cfg_we,
	input  logic [gid_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [gid_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output int                                 errors,
	output int                                 reports_due
);

	// Register copies.
	logic [gid_pkg::DEB_BITS-1:0]  debounce_ticks;
	logic                          filter_mode;
	logic [gid_pkg::TRIG_BITS-1:0] trigger_type;

	// Debounce state copies.
	logic [TICK_BITS-1:0]         tick_now;
	logic [TICK_BITS-1:0]         last_report_tick;
	logic                         latched_level;
	logic [gid_pkg::DEB_BITS-1:0] delay_count;
	logic                         delay_running;

	// Levels still owed on the report channel, oldest first.
	logic expected_levels[$];
	logic oldest_level;
	int   fail_count;

	// Prints one mismatch line and counts it.
	task automatic report_mismatch(input string msg);
		$display("gid_checker: %0t: %s", $time, msg);
		fail_count++;
	endtask

	// Whether a confirmed level suits the current trigger type.
	function automatic logic level_qualifies(input logic lvl);
		case (trigger_type)
			gid_pkg::TRIG_RISING, gid_pkg::TRIG_HIGH: return lvl == 1'b1;
			gid_pkg::TRIG_FALLING, gid_pkg::TRIG_LOW: return lvl == 1'b0;
			default: return 1'b1;
		endcase
	endfunction

	// A write to the timing registers clears the stamp and may drop a pending delay.
	task automatic apply_register_write(input logic [gid_pkg::CFG_INDEX_BITS-1:0] idx,
			input logic [gid_pkg::CFG_DATA_BITS-1:0] data);
		case (idx)
			gid_pkg::REG_TRIGGER_TYPE: trigger_type = data[gid_pkg::TRIG_BITS-1:0];
			gid_pkg::REG_DEBOUNCE_TICKS, gid_pkg::REG_FILTER_MODE: begin
				if (idx == gid_pkg::REG_DEBOUNCE_TICKS)
					debounce_ticks = data[gid_pkg::DEB_BITS-1:0];
				else
					filter_mode = data[0];
				last_report_tick = '0;
				if (filter_mode == gid_pkg::MODE_COOLDOWN || debounce_ticks == '0) begin
					delay_running = 1'b0;
					delay_count = '0;
				end
			end
			default: ;
		endcase
	endtask

	// Advances the debounce state by one request and queues any report it causes.
	task automatic predict_debounce(input logic act, input logic lvl);
		logic [TICK_BITS-1:0] distance;
		if (act == gid_pkg::ACT_TICK) begin
			tick_now = tick_now + 1'b1;
			if (delay_running) begin
				if (delay_count != '0)
					delay_count = delay_count - 1'b1;
				if (delay_count == '0) begin
					delay_running = 1'b0;
					if (latched_level == lvl && level_qualifies(latched_level))
						expected_levels.push_back(latched_level);
				end
			end
		end else if (debounce_ticks == '0) begin
			expected_levels.push_back(lvl);
		end else if (filter_mode == gid_pkg::MODE_COOLDOWN) begin
			// Absolute distance between now and the last report, modulo the tick width.
			distance = (tick_now > last_report_tick) ? tick_now - last_report_tick
				: last_report_tick - tick_now;
			if (distance >= debounce_ticks) begin
				last_report_tick = tick_now;
				expected_levels.push_back(lvl);
			end
		end else begin
			latched_level = lvl;
			delay_count = debounce_ticks;
			delay_running = 1'b1;
		end
	endtask

	// Reports are checked before new requests are predicted, so an unexpected
	// report is never matched against a request taken at the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks = '0;
			filter_mode = gid_pkg::MODE_COOLDOWN;
			trigger_type = gid_pkg::TRIG_BOTH;
			tick_now = '0;
			last_report_tick = '0;
			latched_level = 1'b0;
			delay_count = '0;
			delay_running = 1'b0;
			expected_levels.delete();
		end else begin
			if (results.valid && results.ready) begin
				if (expected_levels.size() == 0) begin
					report_mismatch($sformatf("report of level %b with none expected",
						results.reported_level));
				end else begin
					oldest_level = expected_levels.pop_front();
					if (results.reported_level !== oldest_level)
						report_mismatch($sformatf("reported_level %b, expected %b",
							results.reported_level, oldest_level));
				end
			end
			if (cfg_we)
				apply_register_write(cfg_index, cfg_data);
			if (items.valid && items.ready)
				predict_debounce(items.action, items.pin_level);
		end
		errors <= fail_count;
		reports_due <= expected_levels.size();
	end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// GPIO interrupt debouncer testbench
// Drives directed and random tick and edge requests through directed and random
// register settings, with random idling on both channels, and lets the checker judge
// each report.
// ---------------------------------------------------------------------------
module tb;

	localparam int TICK_BITS     = 32;
	localparam int RANDOM_PHASES = 16;
	localparam int PHASE_ITEMS   = 72;
	localparam int HOLD_CYCLES   = 200;
	localparam int SETTLE_CYCLES = 4;
	localparam int QUIET_LIMIT   = 3000;

	// Codes with no name in the package.
	localparam logic [gid_pkg::TRIG_BITS-1:0]      TRIG_UNUSED = 3'd5;
	localparam logic [gid_pkg::CFG_INDEX_BITS-1:0] REG_NONE    = 2'd3;

	logic                               clk;
	logic                               arst_n;
	logic                               cfg_we;
	logic [gid_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [gid_pkg::CFG_DATA_BITS-1:0]  cfg_data;

	int err_count;
	int reports_due;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_asks;
	int requests_sent;
	int quiet_cycles;

	logic [gid_pkg::DEB_BITS-1:0] cur_debounce;
	logic                         cur_mode;

	gid_in_if  items ();
	gid_out_if results ();

	gpio_interrupt_debouncer #(
		.TICK_BITS(TICK_BITS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.items    (items),
		.results  (results),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	gid_checker #(
		.TICK_BITS(TICK_BITS)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.results    (results),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.errors     (err_count),
		.reports_due(reports_due)
	);

	// 10 ns clock.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Ends the run when neither channel moves for too long.
	always @(posedge clk) begin
		if ((items.valid && items.ready) || (results.valid && results.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// Report receiver: random stalls, plus a long hold-off whenever one is asked for.
	initial begin
		int holds_done;
		results.ready = 1'b0;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (holds_done != hold_asks) begin
				holds_done = hold_asks;
				results.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			results.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Offers one request, idling first at the sender's rate, and returns at acceptance.
	task automatic send_request(input logic act, input logic lvl);
		if ($urandom_range(99) < send_idle_pct) begin
			items.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		items.valid <= 1'b1;
		items.action <= act;
		items.pin_level <= lvl;
		do @(posedge clk); while (!items.ready);
		requests_sent++;
	endtask

	// Stops offering requests until every report is in and the pipeline is empty.
	task automatic wait_reports_drained();
		items.valid <= 1'b0;
		do @(posedge clk); while (reports_due != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write, made only while the block is idle.
	task automatic write_reg(input logic [gid_pkg::CFG_INDEX_BITS-1:0] idx,
			input logic [gid_pkg::CFG_DATA_BITS-1:0] data);
		wait_reports_drained();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == gid_pkg::REG_DEBOUNCE_TICKS)
			cur_debounce = data[gid_pkg::DEB_BITS-1:0];
		else if (idx == gid_pkg::REG_FILTER_MODE)
			cur_mode = data[0];
	endtask

	// Mostly short debounce times so that reports stay frequent.
	function automatic logic [gid_pkg::DEB_BITS-1:0] pick_debounce();
		int roll;
		roll = $urandom_range(99);
		if (roll < 15)
			return '0;
		else if (roll < 70)
			return gid_pkg::DEB_BITS'($urandom_range(6, 1));
		else if (roll < 90)
			return gid_pkg::DEB_BITS'($urandom_range(40, 7));
		else if (roll < 95)
			return '1;
		return gid_pkg::DEB_BITS'($urandom);
	endfunction

	// Writes a random setting of all registers, with random spare data bits.
	task automatic write_random_setting();
		logic [gid_pkg::CFG_DATA_BITS-1:0] data;
		write_reg(gid_pkg::REG_DEBOUNCE_TICKS, gid_pkg::CFG_DATA_BITS'(pick_debounce()));
		data = gid_pkg::CFG_DATA_BITS'($urandom);
		data[0] = ($urandom_range(1) == 0) ? gid_pkg::MODE_COOLDOWN : gid_pkg::MODE_DELAY;
		write_reg(gid_pkg::REG_FILTER_MODE, data);
		data = gid_pkg::CFG_DATA_BITS'($urandom);
		data[gid_pkg::TRIG_BITS-1:0] = gid_pkg::TRIG_BITS'($urandom_range(7));
		write_reg(gid_pkg::REG_TRIGGER_TYPE, data);
		if ($urandom_range(3) == 0)
			write_reg(REG_NONE, gid_pkg::CFG_DATA_BITS'($urandom));
	endtask

	// One random phase. Delay mode mostly gets an edge followed by a run of
	// ticks near the debounce time at a steady level; the rest is noise.
	task automatic run_random_phase(input int count);
		int  first;
		int  run_len;
		int  span;
		logic lvl;
		first = requests_sent;
		while (requests_sent - first < count) begin
			if ($urandom_range(49) == 0)
				wait_reports_drained();
			if (cur_mode == gid_pkg::MODE_DELAY && cur_debounce != '0
					&& $urandom_range(99) < 85) begin
				lvl = 1'($urandom_range(1));
				span = (cur_debounce > 20) ? 20 : int'(cur_debounce) + 2;
				run_len = $urandom_range(span);
				send_request(gid_pkg::ACT_EDGE, lvl);
				repeat (run_len)
					send_request(gid_pkg::ACT_TICK, ($urandom_range(9) == 0) ? ~lvl : lvl);
			end else begin
				send_request(($urandom_range(99) < 40) ? gid_pkg::ACT_EDGE : gid_pkg::ACT_TICK,
					1'($urandom_range(1)));
			end
		end
	endtask

	// Stimulus and verdict.
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		items.valid = 1'b0;
		items.action = gid_pkg::ACT_TICK;
		items.pin_level = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_asks = 0;
		requests_sent = 0;
		cur_debounce = '0;
		cur_mode = gid_pkg::MODE_COOLDOWN;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting: no debouncing, every edge is reported at once.
		send_request(gid_pkg::ACT_EDGE, 1'b0);
		send_request(gid_pkg::ACT_EDGE, 1'b1);
		send_request(gid_pkg::ACT_TICK, 1'b1);

		// Unused trigger code, a write beyond the register list, then cooldown.
		write_reg(gid_pkg::REG_TRIGGER_TYPE, gid_pkg::CFG_DATA_BITS'(TRIG_UNUSED));
		write_reg(REG_NONE, '1);
		write_reg(gid_pkg::REG_DEBOUNCE_TICKS, 16'd3);
		send_request(gid_pkg::ACT_EDGE, 1'b1);
		send_request(gid_pkg::ACT_TICK, 1'b0);
		send_request(gid_pkg::ACT_TICK, 1'b1);
		send_request(gid_pkg::ACT_EDGE, 1'b0);
		send_request(gid_pkg::ACT_EDGE, 1'b1);

		// Delay mode with a rising trigger: a low level is refused, a high one confirmed.
		write_reg(gid_pkg::REG_FILTER_MODE, gid_pkg::CFG_DATA_BITS'(gid_pkg::MODE_DELAY));
		write_reg(gid_pkg::REG_TRIGGER_TYPE, gid_pkg::CFG_DATA_BITS'(gid_pkg::TRIG_RISING));
		send_request(gid_pkg::ACT_EDGE, 1'b0);
		send_request(gid_pkg::ACT_TICK, 1'b0);
		send_request(gid_pkg::ACT_TICK, 1'b0);
		send_request(gid_pkg::ACT_TICK, 1'b0);
		send_request(gid_pkg::ACT_EDGE, 1'b1);
		send_request(gid_pkg::ACT_TICK, 1'b1);
		send_request(gid_pkg::ACT_TICK, 1'b0);
		send_request(gid_pkg::ACT_TICK, 1'b1);

		// A debounce write in the middle of a delay keeps the remaining count.
		send_request(gid_pkg::ACT_EDGE, 1'b1);
		send_request(gid_pkg::ACT_TICK, 1'b1);
		write_reg(gid_pkg::REG_DEBOUNCE_TICKS, '1);
		send_request(gid_pkg::ACT_TICK, 1'b0);
		send_request(gid_pkg::ACT_TICK, 1'b1);

		// Leaving delay mode drops a pending delay; the longest cooldown refuses edges.
		send_request(gid_pkg::ACT_EDGE, 1'b0);
		write_reg(gid_pkg::REG_FILTER_MODE, gid_pkg::CFG_DATA_BITS'(gid_pkg::MODE_COOLDOWN));
		write_reg(gid_pkg::REG_TRIGGER_TYPE, gid_pkg::CFG_DATA_BITS'(gid_pkg::TRIG_LOW));
		send_request(gid_pkg::ACT_EDGE, 1'b1);
		send_request(gid_pkg::ACT_TICK, 1'b0);

		// Long receiver hold-off while edges keep coming, so that both channels stall.
		write_reg(gid_pkg::REG_DEBOUNCE_TICKS, '0);
		hold_asks <= hold_asks + 1;
		repeat (30)
			send_request(gid_pkg::ACT_EDGE, 1'($urandom_range(1)));
		wait_reports_drained();

		// Random phases, rotating through the idling patterns.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					recv_idle_pct <= 0;
				end
				1: begin
					send_idle_pct = 54;
					recv_idle_pct <= 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_idle_pct <= 54;
				end
				default: begin
					send_idle_pct = 10;
					recv_idle_pct <= 10;
				end
			endcase
			write_random_setting();
			run_random_phase(PHASE_ITEMS);
		end

		wait_reports_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0 && reports_due == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
